[sv/run_length_row_decoder_assert.svh]
// ----------------------------------------------------------------------------
// Run-length row decoder assertion macros
// Concurrent checks clocked on the rising edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef RUN_LENGTH_ROW_DECODER_ASSERT_SVH
`define RUN_LENGTH_ROW_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define RLRD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("run_length_row_decoder: assertion failed");

// Next-cycle implication
`define RLRD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("run_length_row_decoder: assertion failed");

`else

`define RLRD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RLRD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/rlrd_pkg.sv]
// ----------------------------------------------------------------------------
// rlrd_pkg
// Shared types, character codes and status codes of the run-length row decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rlrd_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int QUEUE_DEPTH = 4;

  localparam int CHAR_W  = 8;
  localparam int ROW_W   = 10;
  localparam int COL_W   = 10;
  localparam int CNT_W   = 11;
  localparam int STAT_W  = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CNT_W-1:0] COUNT_SAT     = 11'd2047;
  localparam logic [CNT_W-1:0] COL_COUNT_RST = 11'd1024;
  localparam logic [CNT_W-1:0] MAX_COL_LIM   = CNT_W'(MAX_COLUMNS);

  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_O    = 8'h4F;
  localparam logic [CHAR_W-1:0] CH_SP   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADCHAR  = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd3;

  typedef logic [1:0] char_class_t;
  localparam char_class_t CLS_DIGIT = 2'd0;
  localparam char_class_t CLS_SYM   = 2'd1;
  localparam char_class_t CLS_SKIP  = 2'd2;
  localparam char_class_t CLS_BAD   = 2'd3;

  // One classified character on its way to the back end
  typedef struct packed {
    char_class_t        cls;
    logic [3:0]         digit;
    logic               is_o;
    logic [ROW_W-1:0]   row;
    logic               last;
  } item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

`default_nettype wire

[sv/rlrd_front.sv]
// ----------------------------------------------------------------------------
// rlrd_front
// Accepts characters and classifies them as digit, symbol, skip or bad.
// ----------------------------------------------------------------------------
`default_nettype none

module rlrd_front (
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [rlrd_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                               in_tlast,
  input  wire rlrd_pkg::q_stat_t                  q_stat,
  output logic                                    push,
  output rlrd_pkg::item_t                         push_item
);
  import rlrd_pkg::*;

  logic [CHAR_W-1:0] ch;
  logic [CHAR_W-1:0] ch_off;

  assign ch        = in_tdata[CHAR_W-1:0];
  assign ch_off    = ch - CH_ZERO;
  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;

  always_comb begin
    push_item.digit = ch_off[3:0];
    push_item.is_o  = (ch == CH_O);
    push_item.row   = in_tdata[CHAR_W +: ROW_W];
    push_item.last  = in_tlast;
    if (ch inside {[CH_ZERO:CH_NINE]}) begin
      push_item.cls = CLS_DIGIT;
    end else if (ch inside {CH_X, CH_O}) begin
      push_item.cls = CLS_SYM;
    end else if (ch inside {CH_SP, CH_LF, CH_CR}) begin
      push_item.cls = CLS_SKIP;
    end else begin
      push_item.cls = CLS_BAD;
    end
  end

endmodule

`default_nettype wire

[sv/rlrd_queue.sv]
// ----------------------------------------------------------------------------
// rlrd_queue
// Short first-in first-out queue between the classifier and the decode back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rlrd_queue #(
  parameter int DEPTH = rlrd_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire rlrd_pkg::item_t     push_item,
  input  wire logic                pop,
  output rlrd_pkg::item_t          pop_item,
  output rlrd_pkg::q_stat_t        q_stat
);
  import rlrd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

  item_t              slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;

  assign pop_item     = slot_r[rd_ptr_r];
  assign q_stat.full  = (fill_r == FILL_MAX);
  assign q_stat.valid = (fill_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

[sv/rlrd_back.sv]
// ----------------------------------------------------------------------------
// rlrd_back
// Builds run counts, tracks the column position and errors, registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module rlrd_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [rlrd_pkg::CNT_W-1:0]         cfg_wdata,
  input  wire rlrd_pkg::q_stat_t                  q_stat,
  input  wire rlrd_pkg::item_t                    pop_item,
  output logic                                    pop,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [rlrd_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                    out_tlast,
  output logic                                    out_tuser
);
  import rlrd_pkg::*;

  logic [CNT_W-1:0]  col_count_r;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [STAT_W-1:0] err_r, err_nxt;
  logic [14:0]       dec_sum;
  logic [CNT_W:0]    end_pos;
  logic              row_ok;

  logic              res_valid;
  logic [ROW_W-1:0]  res_row;
  logic [COL_W-1:0]  res_start;
  logic [CNT_W-1:0]  res_len;
  logic              res_is_o;
  logic [STAT_W-1:0] res_status;

  logic              out_valid_r;
  logic              run_valid_r;
  logic [ROW_W-1:0]  run_row_r;
  logic [COL_W-1:0]  run_start_r;
  logic [CNT_W-1:0]  run_len_r;
  logic              is_o_r;
  logic              done_r;
  logic [STAT_W-1:0] status_r;

  assign lim     = (col_count_r > MAX_COL_LIM) ? MAX_COL_LIM : col_count_r;
  assign pop     = q_stat.valid && (!out_valid_r || out_tready);
  // count * 10 + digit, as two shifts and adds
  assign dec_sum = {1'b0, cnt_r, 3'b000} + {3'b000, cnt_r, 1'b0} + {11'd0, pop_item.digit};
  assign end_pos = {1'b0, pos_r} + {1'b0, cnt_r};
  assign row_ok  = (32'(pop_item.row) < MAX_ROWS);

  always_comb begin
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    err_nxt    = err_r;
    res_valid  = 1'b0;
    res_row    = '0;
    res_start  = '0;
    res_len    = '0;
    res_is_o   = 1'b0;
    res_status = ST_OK;
    if (err_r == ST_OK) begin
      case (pop_item.cls)
        CLS_DIGIT: begin
          cnt_nxt = (dec_sum > 15'(COUNT_SAT)) ? COUNT_SAT : dec_sum[CNT_W-1:0];
        end
        CLS_SYM: begin
          cnt_nxt = '0;
          if (end_pos > {1'b0, lim}) begin
            err_nxt = ST_OVERFLOW;
          end else if (cnt_r != '0) begin
            if (row_ok) begin
              res_valid = 1'b1;
              res_row   = pop_item.row;
              res_start = pos_r[COL_W-1:0];
              res_len   = cnt_r;
              res_is_o  = pop_item.is_o;
            end
            pos_nxt = end_pos[CNT_W-1:0];
          end
        end
        CLS_BAD: begin
          err_nxt = ST_BADCHAR;
        end
        default: begin
        end
      endcase
    end
    // close the row: report status and start the next one clean
    if (pop_item.last) begin
      if (err_nxt == ST_OK && pos_nxt != lim) begin
        res_status = ST_MISMATCH;
      end else begin
        res_status = err_nxt;
      end
      cnt_nxt = '0;
      pos_nxt = '0;
      err_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= COL_COUNT_RST;
      cnt_r       <= '0;
      pos_r       <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        col_count_r <= cfg_wdata;
      end
      if (pop) begin
        cnt_r       <= cnt_nxt;
        pos_r       <= pos_nxt;
        err_r       <= err_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      run_valid_r <= res_valid;
      run_row_r   <= res_row;
      run_start_r <= res_start;
      run_len_r   <= res_len;
      is_o_r      <= res_is_o;
      done_r      <= pop_item.last;
      status_r    <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = run_valid_r;
  assign out_tlast  = done_r;
  assign out_tdata  = {6'd0, status_r, is_o_r, run_len_r, run_start_r, run_row_r};

endmodule

`default_nettype wire

[sv/run_length_row_decoder.sv]
// ----------------------------------------------------------------------------
// run_length_row_decoder
// Decodes count-then-symbol row text (such as 3X2O) into run descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one character per request; in_tdata carries the character
//   and the row index, in_tlast marks the final character of a row.
//   Output stream: exactly one result per character. out_tuser flags a run
//   of nonzero length (row, start column, length, symbol in out_tdata);
//   out_tlast closes the row and out_tdata then carries its status.
//   Config: cfg_we writes the row length (cells per row) from cfg_wdata;
//   write it only while no character is in flight.
//   Path: a character is stored in a queue slot, then its result is
//   held in the output register. Throughput: one character per cycle while
//   out_tready is high; count, position and error update per character.
//   Reset: rst_n low clears the queue, the row state and the output
//   register and loads a row length of 1024.
//   Stall: a result waits in the output register while out_tready is low;
//   the queue keeps taking characters until it holds QUEUE_DEPTH of them,
//   then in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_row_decoder #(
  parameter int QUEUE_DEPTH = rlrd_pkg::QUEUE_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // config: row length
  input  wire logic                               cfg_we,
  input  wire logic [rlrd_pkg::CNT_W-1:0]         cfg_wdata,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [7:0] character_code, [17:8] row_index, [23:18] zero
  input  wire logic [rlrd_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                               in_tlast,
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [9:0] run_row, [19:10] run_start, [30:20] run_length, [31] cell_is_o,
  // [33:32] status, [39:34] zero
  output logic [rlrd_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                    out_tlast,
  // [0] run_valid
  output logic                                    out_tuser
);
  import rlrd_pkg::*;

  q_stat_t q_stat;
  item_t   push_item;
  item_t   pop_item;
  logic    push;
  logic    pop;

  rlrd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  rlrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  rlrd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_stat     (q_stat),
    .pop_item   (pop_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`include "run_length_row_decoder_assert.svh"

  // an emitted run is never empty
  `RLRD_ASSERT_IMP(a_run_nonempty, clk, rst_n, out_tvalid && out_tuser, out_tdata[30:20] != 11'd0)
  // status is reported on the row's last result only
  `RLRD_ASSERT_IMP(a_status_last, clk, rst_n, out_tvalid && !out_tlast, out_tdata[33:32] == ST_OK)
  // a run can only come from a row that was error free up to it
  `RLRD_ASSERT_IMP(a_run_status, clk, rst_n, out_tvalid && out_tuser, out_tdata[33:32] == ST_OK || out_tdata[33:32] == ST_MISMATCH)
  // with nothing ahead of it, a character passes the queue, then shows in the output register
  `RLRD_ASSERT_NXT(a_latency, clk, rst_n, in_tvalid && in_tready && !q_stat.valid && !out_tvalid, ##1 out_tvalid)

endmodule

`default_nettype wire
